@@ src/sprd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprd_pkg
// Shared types and constants of the sprite run-length decoder.
// ----------------------------------------------------------------------------
package sprd_pkg;

  // Largest frame dimension that can be addressed.
  localparam int unsigned MAX_DIM = 256;

  // Counter widths and saturation limit.
  localparam int unsigned CNT_W   = 9;
  localparam int unsigned RUN_W   = 7;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COORD_W = 8;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Configuration register indexes (byte address = 4 * index).
  localparam int unsigned CFG_AW = 3;
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Reset value of both dimension registers.
  localparam logic [CNT_W-1:0] DIM_RESET = CNT_W'(256);

  // Decoder state carried from item to item.
  typedef struct packed {
    logic [RUN_W-1:0] run_remaining;
    logic [CNT_W-1:0] column;
    logic [CNT_W-1:0] row;
    logic             finished;
  } sprd_state_t;

  // One input item.
  typedef struct packed {
    logic [BYTE_W-1:0] stream_byte;
    logic              first_byte;
    logic              last_byte;
  } sprd_in_t;

  // One result item.
  typedef struct packed {
    logic               write_enable;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [BYTE_W-1:0]  pixel_value;
    logic               frame_done;
  } sprd_out_t;

endpackage

@@ src/sprd_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprd_step
// Combinational decode of one stream byte: next decoder state and the result.
// ----------------------------------------------------------------------------
module sprd_step (
  input  sprd_pkg::sprd_state_t    state_i,
  input  sprd_pkg::sprd_in_t       item_i,
  input  logic [sprd_pkg::CNT_W-1:0] width_i,
  input  logic [sprd_pkg::CNT_W-1:0] height_i,
  output sprd_pkg::sprd_state_t    state_o,
  output sprd_pkg::sprd_out_t      result_o
);

  sprd_pkg::sprd_state_t cur;
  logic [sprd_pkg::CNT_W:0] col_skip;
  logic [sprd_pkg::CNT_W:0] col_inc;
  logic [sprd_pkg::CNT_W:0] row_inc;
  logic [sprd_pkg::CNT_W-1:0] row_sat;
  logic [sprd_pkg::CNT_W:0] skip_amt;
  logic in_frame;

  // Start of frame clears everything before the byte is looked at
  always_comb begin
    cur = state_i;
    if (item_i.first_byte) begin
      cur = '0;
    end
  end

  // Saturating counter updates
  always_comb begin
    skip_amt = (sprd_pkg::CNT_W+1)'(256) -
               (sprd_pkg::CNT_W+1)'(item_i.stream_byte);
    col_skip = {1'b0, cur.column} + skip_amt;
    col_inc  = {1'b0, cur.column} + (sprd_pkg::CNT_W+1)'(1);
    row_inc  = {1'b0, cur.row} + (sprd_pkg::CNT_W+1)'(1);
    row_sat  = row_inc[sprd_pkg::CNT_W] ? sprd_pkg::CNT_MAX
                                         : row_inc[sprd_pkg::CNT_W-1:0];
    in_frame = (cur.column < width_i) &&
               (32'(cur.column) < 32'(sprd_pkg::MAX_DIM)) &&
               (32'(cur.row) < 32'(sprd_pkg::MAX_DIM));
  end

  // Command / literal decode
  always_comb begin
    state_o  = cur;
    result_o = '0;
    if (!cur.finished) begin
      if (cur.row >= height_i) begin
        state_o.finished = 1'b1;
      end else begin
        if (cur.run_remaining != '0) begin
          // palette byte of an open literal run
          if (in_frame) begin
            result_o.write_enable = 1'b1;
            result_o.pixel_x      = cur.column[sprd_pkg::COORD_W-1:0];
            result_o.pixel_y      = cur.row[sprd_pkg::COORD_W-1:0];
            result_o.pixel_value  = item_i.stream_byte;
          end
          state_o.column = col_inc[sprd_pkg::CNT_W] ? sprd_pkg::CNT_MAX
                                                     : col_inc[sprd_pkg::CNT_W-1:0];
          state_o.run_remaining = cur.run_remaining - sprd_pkg::RUN_W'(1);
        end else if (item_i.stream_byte == '0) begin
          // end of row
          state_o.row    = row_sat;
          state_o.column = '0;
          if (row_sat >= height_i) begin
            state_o.finished = 1'b1;
          end
        end else if (item_i.stream_byte[sprd_pkg::BYTE_W-1]) begin
          // transparent skip
          state_o.column = col_skip[sprd_pkg::CNT_W] ? sprd_pkg::CNT_MAX
                                                      : col_skip[sprd_pkg::CNT_W-1:0];
        end else begin
          // open literal run
          state_o.run_remaining = item_i.stream_byte[sprd_pkg::RUN_W-1:0];
        end
        if (item_i.last_byte) begin
          state_o.finished = 1'b1;
        end
      end
    end
    result_o.frame_done = state_o.finished;
  end

endmodule

@@ src/sprite_rle_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_rle_decoder
// Run-length sprite stream decoder, one byte in and one pixel result out.
// ----------------------------------------------------------------------------
// Takes one stream byte per item and returns exactly one result per byte,
// carrying an optional pixel write (in tuser) and a frame-done flag (in tlast).
// The block sustains one item per clock while the output is not stalled: a byte
// passes an input register, one level of decode and counter logic, and an
// output register before its result appears on the output. Throughput is set
// by the row/column/run update loop. The destination frame must be cleared by
// the consumer. Program width and height through the APB port only while no
// item is in flight.
// ----------------------------------------------------------------------------
module sprite_rle_decoder (
  input  logic                         clk,
  input  logic                         rst_n,
  // input stream
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // [7:0] stream_byte
  input  logic [0:0]                   in_tuser,   // [0] first_byte
  input  logic                         in_tlast,   // last_byte
  // result stream
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [23:0]                  out_tdata,  // [7:0] pixel_x, [15:8] pixel_y,
                                                   // [23:16] pixel_value
  output logic [0:0]                   out_tuser,  // [0] write_enable
  output logic                         out_tlast,  // frame_done
  // configuration
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [sprd_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);

  logic [sprd_pkg::CNT_W-1:0] width_r, width_nxt;
  logic [sprd_pkg::CNT_W-1:0] height_r, height_nxt;
  logic                       cfg_wr;

  sprd_pkg::sprd_state_t state_r, state_nxt;
  sprd_pkg::sprd_in_t    item_r, item_nxt;
  logic                  item_vld_r, item_vld_nxt;
  sprd_pkg::sprd_out_t   res_r, res_nxt;
  logic                  res_vld_r, res_vld_nxt;

  sprd_pkg::sprd_state_t step_state;
  sprd_pkg::sprd_out_t   step_res;
  logic                  out_free;
  logic                  advance;
  logic                  in_acc;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_wr) begin
      if (cfg_paddr[2] == sprd_pkg::REG_WIDTH) begin
        width_nxt = cfg_pwdata[sprd_pkg::CNT_W-1:0];
      end else begin
        height_nxt = cfg_pwdata[sprd_pkg::CNT_W-1:0];
      end
    end
  end

  always_comb begin
    if (cfg_paddr[2] == sprd_pkg::REG_HEIGHT) begin
      cfg_prdata = 32'(height_r);
    end else begin
      cfg_prdata = 32'(width_r);
    end
  end

  // Decode of the registered item
  sprd_step u_step (
    .state_i  (state_r),
    .item_i   (item_r),
    .width_i  (width_r),
    .height_i (height_r),
    .state_o  (step_state),
    .result_o (step_res)
  );

  // Pipeline handshake: input register feeds output register
  assign out_free  = !res_vld_r || out_tready;
  assign advance   = item_vld_r && out_free;
  assign in_tready = !item_vld_r || advance;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    item_nxt     = item_r;
    item_vld_nxt = item_vld_r;
    if (in_acc) begin
      item_nxt.stream_byte = in_tdata;
      item_nxt.first_byte  = in_tuser[0];
      item_nxt.last_byte   = in_tlast;
      item_vld_nxt         = 1'b1;
    end else if (advance) begin
      item_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    res_nxt     = res_r;
    res_vld_nxt = res_vld_r;
    if (advance) begin
      state_nxt   = step_state;
      res_nxt     = step_res;
      res_vld_nxt = 1'b1;
    end else if (out_tready) begin
      res_vld_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= sprd_pkg::DIM_RESET;
      height_r   <= sprd_pkg::DIM_RESET;
      state_r    <= '0;
      item_vld_r <= 1'b0;
      res_vld_r  <= 1'b0;
    end else begin
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      state_r    <= state_nxt;
      item_vld_r <= item_vld_nxt;
      res_vld_r  <= res_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
  end

  // Result ports
  assign out_tvalid = res_vld_r;
  assign out_tdata  = {res_r.pixel_value, res_r.pixel_y, res_r.pixel_x};
  assign out_tuser  = res_r.write_enable;
  assign out_tlast  = res_r.frame_done;

endmodule

@@ tb/sv/tb_sprite_rle_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sprite_rle_decoder
// Self-checking bench for the sprite run-length decoder.
// ----------------------------------------------------------------------------
// A short directed table, walked by a loop, covers skips, literal runs, column
// saturation, clipping, last byte inside a run and bytes after done. Random
// sprite frames follow under a series of width/height settings, with noise
// and truncated frames mixed in. Every accepted byte is decoded by a local
// model of the decoder and each result item is compared field by field.
// Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_sprite_rle_decoder;

  localparam int N_DIRECTED = 22;
  localparam int N_PHASES   = 7;
  localparam int RAND_ITEMS = 1450;

  // directed row: stimulus, whether the result is typed in, and that result
  typedef struct packed {
    sprd_pkg::sprd_in_t  stim;
    logic                typed;
    sprd_pkg::sprd_out_t want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] stream_byte
  logic [0:0]  in_tuser = '0;   // [0] first_byte
  logic        in_tlast = 1'b0; // last_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // [7:0] pixel_x, [15:8] pixel_y, [23:16] pixel_value
  logic [0:0]  out_tuser;       // [0] write_enable
  logic        out_tlast;       // frame_done
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [sprd_pkg::CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // local decoder model state
  logic [sprd_pkg::RUN_W-1:0] run_left;
  logic [sprd_pkg::CNT_W-1:0] col;
  logic [sprd_pkg::CNT_W-1:0] row_idx;
  logic                       frame_fin;
  logic [sprd_pkg::CNT_W-1:0] width_reg;
  logic [sprd_pkg::CNT_W-1:0] height_reg;

  sprd_pkg::sprd_out_t pending_pixels[$];
  dir_row_t            dir_rows [N_DIRECTED];
  sprd_pkg::sprd_in_t  frame_q[$];

  int mismatches = 0;
  int sent = 0;
  int live_items = 0;
  int pixel_writes = 0;
  int done_results = 0;
  int in_idle_pct = 7;
  int out_stall_pct = 46;

  // per-phase byte budget; the tall phase sends frames one row taller than its height
  int phase_w     [N_PHASES] = '{1, 17, 511, 0, 0, 256, 200};
  int phase_h     [N_PHASES] = '{1, 5, 300, 0, 511, 256, 3};
  int phase_quota [N_PHASES] = '{160, 180, 200, 30, 100, 200, 160};
  bit phase_tall  [N_PHASES] = '{0, 0, 1, 0, 0, 0, 0};

  sprite_rle_decoder dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #1 clk = ~clk;

  // saturating 9-bit counter add
  function automatic logic [sprd_pkg::CNT_W-1:0] sat_count(
      input logic [sprd_pkg::CNT_W-1:0] a,
      input logic [sprd_pkg::CNT_W-1:0] b);
    logic [sprd_pkg::CNT_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[sprd_pkg::CNT_W] ? sprd_pkg::CNT_MAX : sum[sprd_pkg::CNT_W-1:0];
  endfunction

  // decode one stream byte, advance the model state, return the pixel result
  function automatic sprd_pkg::sprd_out_t decode_byte(input sprd_pkg::sprd_in_t it);
    sprd_pkg::sprd_out_t res;
    res = '0;
    if (it.first_byte) begin
      run_left  = '0;
      col       = '0;
      row_idx   = '0;
      frame_fin = 1'b0;
    end
    if (!frame_fin) begin
      if (row_idx >= height_reg) begin
        frame_fin = 1'b1;
      end else begin
        live_items++;
        if (run_left != '0) begin
          // palette byte of an open literal run
          if (col < width_reg && col < sprd_pkg::MAX_DIM && row_idx < sprd_pkg::MAX_DIM) begin
            res.write_enable = 1'b1;
            res.pixel_x      = col[sprd_pkg::COORD_W-1:0];
            res.pixel_y      = row_idx[sprd_pkg::COORD_W-1:0];
            res.pixel_value  = it.stream_byte;
          end
          col      = sat_count(col, sprd_pkg::CNT_W'(1));
          run_left = run_left - sprd_pkg::RUN_W'(1);
        end else if (it.stream_byte == '0) begin
          // end of row
          row_idx = sat_count(row_idx, sprd_pkg::CNT_W'(1));
          col     = '0;
          if (row_idx >= height_reg) frame_fin = 1'b1;
        end else if (it.stream_byte[7]) begin
          // transparent skip
          col = sat_count(col, sprd_pkg::CNT_W'(256) - {1'b0, it.stream_byte});
        end else begin
          run_left = it.stream_byte[sprd_pkg::RUN_W-1:0];
        end
        if (it.last_byte) frame_fin = 1'b1;
      end
    end
    res.frame_done = frame_fin;
    return res;
  endfunction

  // push one item through the input handshake and log its expected result
  task automatic send_item(input sprd_pkg::sprd_in_t it, input logic typed,
                           input sprd_pkg::sprd_out_t want);
    sprd_pkg::sprd_out_t pred;
    if (sent < 520) begin
      in_idle_pct = 7;
      out_stall_pct = 46;
    end else if (sent < 1040) begin
      in_idle_pct = 46;
      out_stall_pct = 7;
    end else begin
      in_idle_pct = 0;
      out_stall_pct = 0;
    end
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid   <= 1'b1;
    in_tdata    <= it.stream_byte;
    in_tuser[0] <= it.first_byte;
    in_tlast    <= it.last_byte;
    do @(posedge clk); while (!in_tready);
    pred = decode_byte(it);
    pending_pixels.push_back(typed ? want : pred);
    sent++;
  endtask

  task automatic send_noise();
    sprd_pkg::sprd_in_t it;
    it.stream_byte = 8'($urandom_range(255));
    it.first_byte  = 1'b0;
    it.last_byte   = ($urandom_range(99) < 20);
    send_item(it, 1'b0, '0);
  endtask

  // build a random sprite frame row by row, maybe cut short, then send it
  task automatic send_frame(input int rows_n, input int busy_pct);
    sprd_pkg::sprd_in_t it;
    int n_cmd;
    int run_len;
    int k;
    int cut;
    frame_q.delete();
    it = '0;
    for (int r = 0; r < rows_n; r++) begin
      if ($urandom_range(99) < busy_pct) begin
        n_cmd = $urandom_range(1, 3);
        for (int c = 0; c < n_cmd; c++) begin
          if ($urandom_range(1) == 0) begin
            it.stream_byte = 8'($urandom_range(128, 255));
            frame_q.push_back(it);
          end else begin
            run_len = ($urandom_range(99) < 3) ? $urandom_range(64, 127)
                                               : $urandom_range(1, 6);
            it.stream_byte = 8'(run_len);
            frame_q.push_back(it);
            for (int p = 0; p < run_len; p++) begin
              it.stream_byte = 8'($urandom_range(255));
              frame_q.push_back(it);
            end
          end
        end
      end
      it.stream_byte = 8'h00;
      frame_q.push_back(it);
    end
    frame_q[0].first_byte = 1'b1;
    k = $urandom_range(99);
    if (k < 30) begin
      frame_q[frame_q.size()-1].last_byte = 1'b1;
    end else if (k < 45) begin
      // data runs out early
      cut = $urandom_range(frame_q.size() - 1);
      while (frame_q.size() > cut + 1) void'(frame_q.pop_back());
      frame_q[cut].last_byte = 1'b1;
    end
    foreach (frame_q[i]) send_item(frame_q[i], 1'b0, '0);
    if ($urandom_range(99) < 15) begin
      k = $urandom_range(1, 3);
      repeat (k) send_noise();
    end
  endtask

  // drain the pipe before touching the registers
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write followed by a read-back of the same register
  task automatic write_dim(input logic idx, input logic [sprd_pkg::CNT_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (idx == sprd_pkg::REG_WIDTH) width_reg = value;
    else height_reg = value;
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== 32'(value)) begin
      $error("prdata: expected %0d, got %0d", value, cfg_prdata);
      mismatches++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // result side: random stalls and the field-by-field compare
  always @(posedge clk) begin : result_check
    sprd_pkg::sprd_out_t got;
    sprd_pkg::sprd_out_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.write_enable = out_tuser[0];
      got.pixel_x      = out_tdata[7:0];
      got.pixel_y      = out_tdata[15:8];
      got.pixel_value  = out_tdata[23:16];
      got.frame_done   = out_tlast;
      if (pending_pixels.size() == 0) begin
        $error("result item with nothing expected");
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        if (got.write_enable !== want.write_enable) begin
          $error("write_enable: expected %0d, got %0d", want.write_enable, got.write_enable);
          mismatches++;
        end
        if (got.pixel_x !== want.pixel_x) begin
          $error("pixel_x: expected %0d, got %0d", want.pixel_x, got.pixel_x);
          mismatches++;
        end
        if (got.pixel_y !== want.pixel_y) begin
          $error("pixel_y: expected %0d, got %0d", want.pixel_y, got.pixel_y);
          mismatches++;
        end
        if (got.pixel_value !== want.pixel_value) begin
          $error("pixel_value: expected %0d, got %0d", want.pixel_value, got.pixel_value);
          mismatches++;
        end
        if (got.frame_done !== want.frame_done) begin
          $error("frame_done: expected %0d, got %0d", want.frame_done, got.frame_done);
          mismatches++;
        end
        if (want.write_enable) pixel_writes++;
        if (want.frame_done) done_results++;
      end
    end
    out_tready <= ($urandom_range(99) >= out_stall_pct);
  end

  // main sequence
  initial begin
    int phase_start_sent;
    int rows_n;
    // byte, first, last | typed | write_enable, x, y, value, frame_done
    dir_rows = '{
      {8'h00, 1'b1, 1'b0, 1'b1, 1'b0, 8'd0, 8'd0, 8'h00, 1'b0},  // row ends
      {8'h02, 1'b0, 1'b0, 1'b1, 1'b0, 8'd0, 8'd0, 8'h00, 1'b0},  // run of 2
      {8'hFF, 1'b0, 1'b0, 1'b1, 1'b1, 8'd0, 8'd1, 8'hFF, 1'b0},
      {8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 8'd1, 8'd1, 8'h00, 1'b0},  // zero palette byte
      {8'h80, 1'b0, 1'b0, 1'b1, 1'b0, 8'd0, 8'd0, 8'h00, 1'b0},  // skip 128
      {8'h80, 1'b0, 1'b0, 1'b1, 1'b0, 8'd0, 8'd0, 8'h00, 1'b0},
      {8'h80, 1'b0, 1'b0, 1'b1, 1'b0, 8'd0, 8'd0, 8'h00, 1'b0},
      {8'h80, 1'b0, 1'b0, 1'b1, 1'b0, 8'd0, 8'd0, 8'h00, 1'b0},  // column saturates
      {8'h01, 1'b0, 1'b0, 1'b1, 1'b0, 8'd0, 8'd0, 8'h00, 1'b0},
      {8'hAA, 1'b0, 1'b0, 1'b1, 1'b0, 8'd0, 8'd0, 8'h00, 1'b0},  // clipped pixel
      {8'h81, 1'b0, 1'b0, 1'b1, 1'b0, 8'd0, 8'd0, 8'h00, 1'b0},  // skip 127 at max
      {8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 8'd0, 8'd0, 8'h00, 1'b0},
      {8'h7F, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, 8'h00, 1'b0},  // longest run
      {8'h3C, 1'b0, 1'b0, 1'b1, 1'b1, 8'd0, 8'd2, 8'h3C, 1'b0},
      {8'hC3, 1'b0, 1'b0, 1'b1, 1'b1, 8'd1, 8'd2, 8'hC3, 1'b0},  // high bit as palette
      {8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 8'd2, 8'd2, 8'h00, 1'b1},  // last inside a run
      {8'h05, 1'b0, 1'b0, 1'b1, 1'b0, 8'd0, 8'd0, 8'h00, 1'b1},  // ignored after done
      {8'h01, 1'b1, 1'b1, 1'b1, 1'b0, 8'd0, 8'd0, 8'h00, 1'b1},
      {8'h03, 1'b1, 1'b0, 1'b1, 1'b0, 8'd0, 8'd0, 8'h00, 1'b0},
      {8'h5A, 1'b0, 1'b0, 1'b1, 1'b1, 8'd0, 8'd0, 8'h5A, 1'b0},
      {8'hFF, 1'b0, 1'b1, 1'b1, 1'b1, 8'd1, 8'd0, 8'hFF, 1'b1},
      {8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 8'd0, 8'd0, 8'h00, 1'b1}   // row end, then last
    };
    run_left   = '0;
    col        = '0;
    row_idx    = '0;
    frame_fin  = 1'b0;
    width_reg  = sprd_pkg::DIM_RESET;
    height_reg = sprd_pkg::DIM_RESET;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed part under the reset dimensions
    for (int i = 0; i < N_DIRECTED; i++)
      send_item(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);

    // random frames under each dimension setting
    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_idle();
      write_dim(sprd_pkg::REG_WIDTH, sprd_pkg::CNT_W'(phase_w[ph]));
      write_dim(sprd_pkg::REG_HEIGHT, sprd_pkg::CNT_W'(phase_h[ph]));
      phase_start_sent = sent;
      // stray bytes first: they meet whatever row the last frame left behind
      send_noise();
      send_noise();
      while (sent - phase_start_sent < phase_quota[ph]) begin
        if (phase_tall[ph])
          rows_n = phase_h[ph] + 1;
        else if (phase_h[ph] > 8)
          rows_n = $urandom_range(1, 8);
        else
          rows_n = $urandom_range(1, phase_h[ph] + 1);
        send_frame(rows_n, phase_tall[ph] ? 10 : 60);
        if ($urandom_range(99) < 10) send_noise();
      end
    end

    wait_idle();
    $display("Sent %0d bytes (%0d decoded, target %0d) over %0d dimension settings,",
             sent, live_items, RAND_ITEMS, N_PHASES);
    $display("checked %0d pixel writes and %0d done results.", pixel_writes, done_results);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("Mismatches found");
    $finish;
  end

endmodule
